// ----- rtl/core/ttt_pkg.sv -----
// ----------------------------------------------------------------------------
// ttt_pkg
// Shared types, codes and constants of the tap and external tempo tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package ttt_pkg;

  // event kinds
  typedef logic [1:0] op_t;
  localparam op_t OP_TAP  = 2'd0;
  localparam op_t OP_EDGE = 2'd1;
  localparam op_t OP_POLL = 2'd2;

  // register indexes (byte address / 4)
  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_TAP_TO   = 3'd0;
  localparam reg_idx_t REG_EXT_TO   = 3'd1;
  localparam reg_idx_t REG_MIN_BPM  = 3'd2;
  localparam reg_idx_t REG_MAX_BPM  = 3'd3;
  localparam reg_idx_t REG_THRESH   = 3'd4;
  localparam reg_idx_t REG_FALLBACK = 3'd5;

  localparam logic [15:0] TAP_TO_RST   = 16'd2000;
  localparam logic [15:0] EXT_TO_RST   = 16'd2000;
  localparam logic [8:0]  MIN_BPM_RST  = 9'd10;
  localparam logic [8:0]  MAX_BPM_RST  = 9'd300;
  localparam logic [7:0]  THRESH_RST   = 8'd3;
  localparam logic [8:0]  FALLBACK_RST = 9'd120;
  localparam logic [8:0]  TEMPO_RST    = 9'd120;

  // divider
  localparam int unsigned DIV_W = 18;
  localparam logic [DIV_W-1:0] MS_PER_MIN = 18'd60000;
  localparam logic [DIV_W-1:0] PERIOD_NUM = 18'd156250;
  localparam logic SEL_RAW    = 1'b0;
  localparam logic SEL_PERIOD = 1'b1;

  typedef struct packed {
    logic [15:0] tap_timeout_ms;
    logic [15:0] ext_timeout_ms;
    logic [8:0]  min_bpm;
    logic [8:0]  max_bpm;
    logic [7:0]  change_threshold;
    logic [8:0]  fallback_bpm;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic div_start;
    logic div_sel;
    logic apply_raw;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic raw_req;
    logic div_done;
  } sts_t;

  function automatic logic [8:0] clamp_bpm(input logic [15:0] raw,
                                           input logic [8:0]  lo,
                                           input logic [8:0]  hi);
    logic [8:0] res;
    if (raw < {7'd0, lo}) begin
      res = lo;
    end else if (raw > {7'd0, hi}) begin
      res = hi;
    end else begin
      res = raw[8:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ttt_regs.sv -----
// ----------------------------------------------------------------------------
// ttt_regs
// APB register bank holding the tracker configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module ttt_regs
  import ttt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire reg_idx_t    paddr_idx_i,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t cfg_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tap_timeout_ms   <= TAP_TO_RST;
      cfg_q.ext_timeout_ms   <= EXT_TO_RST;
      cfg_q.min_bpm          <= MIN_BPM_RST;
      cfg_q.max_bpm          <= MAX_BPM_RST;
      cfg_q.change_threshold <= THRESH_RST;
      cfg_q.fallback_bpm     <= FALLBACK_RST;
    end else if (wr_en) begin
      case (paddr_idx_i)
        REG_TAP_TO:   cfg_q.tap_timeout_ms   <= pwdata[15:0];
        REG_EXT_TO:   cfg_q.ext_timeout_ms   <= pwdata[15:0];
        REG_MIN_BPM:  cfg_q.min_bpm          <= pwdata[8:0];
        REG_MAX_BPM:  cfg_q.max_bpm          <= pwdata[8:0];
        REG_THRESH:   cfg_q.change_threshold <= pwdata[7:0];
        REG_FALLBACK: cfg_q.fallback_bpm     <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr_idx_i)
      REG_TAP_TO:   prdata = {16'd0, cfg_q.tap_timeout_ms};
      REG_EXT_TO:   prdata = {16'd0, cfg_q.ext_timeout_ms};
      REG_MIN_BPM:  prdata = {23'd0, cfg_q.min_bpm};
      REG_MAX_BPM:  prdata = {23'd0, cfg_q.max_bpm};
      REG_THRESH:   prdata = {24'd0, cfg_q.change_threshold};
      REG_FALLBACK: prdata = {23'd0, cfg_q.fallback_bpm};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/ttt_div.sv -----
// ----------------------------------------------------------------------------
// ttt_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ttt_div
  import ttt_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DIV_W-1:0] dividend_i,
  input  wire logic [31:0]      divisor_i,
  output logic                  done_o,
  output logic      [DIV_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [31:0]      rem_q;
  logic [31:0]      dvs_q;
  logic [DIV_W-1:0] quot_q;

  logic [32:0] trial;
  logic        ge;
  logic [32:0] rem_d;

  assign trial  = {rem_q, quot_q[DIV_W-1]};
  assign ge     = trial >= {1'b0, dvs_q};
  assign rem_d  = ge ? (trial - {1'b0, dvs_q}) : trial;
  assign done_o = done_q;
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= 32'd0;
      dvs_q  <= divisor_i;
      quot_q <= dividend_i;
    end else if (busy_q) begin
      rem_q  <= rem_d[31:0];
      quot_q <= {quot_q[DIV_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ttt_dp.sv -----
// ----------------------------------------------------------------------------
// ttt_dp
// Tracker datapath: event registers, tap capture, edge timing, tempo and
// result registers, and the shared divider.
// ----------------------------------------------------------------------------
`default_nettype none

module ttt_dp
  import ttt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cmd_t        cmd_i,
  input  wire op_t         op_i,
  input  wire logic [31:0] now_i,
  input  wire cfg_t        cfg_i,
  output sts_t             sts_o,
  output logic      [8:0]  bpm_o,
  output logic      [17:0] period_o,
  output logic             ext_o,
  output logic             upd_o,
  output logic             restart_o
);

  op_t         op_q;
  logic [31:0] now_q;
  logic [8:0]  tempo_q;
  logic [31:0] t0_q;
  logic [2:0]  cnt_q;
  logic [31:0] last_tap_q;
  logic [31:0] last_edge_q;
  logic        ext_q;
  logic        upd_q;
  logic        restart_q;
  logic [31:0] opnd_q;

  logic [8:0]  bpm_q;
  logic [17:0] period_q;
  logic        ext_out_q;
  logic        upd_out_q;
  logic        restart_out_q;

  logic [31:0] tap_gap;
  logic [31:0] edge_gap;
  logic [31:0] span;
  logic [31:0] half;
  logic [2:0]  cnt_eff;
  logic        tap_go;
  logic        tap_third;
  logic        poll_drop;
  logic        raw_req;

  logic             div_done;
  logic [DIV_W-1:0] quot;
  logic [DIV_W-1:0] dividend;
  logic [31:0]      divisor;
  logic [15:0]      raw;
  logic [15:0]      raw_diff;
  logic             retune;

  assign tap_gap   = now_q - last_tap_q;
  assign edge_gap  = now_q - last_edge_q;
  assign span      = now_q - t0_q;
  assign half      = {1'b0, span[31:1]};
  assign cnt_eff   = (tap_gap > {16'd0, cfg_i.tap_timeout_ms}) ? 3'd0 : cnt_q;
  assign tap_go    = (op_q == OP_TAP) && !ext_q;
  assign tap_third = tap_go && (cnt_eff == 3'd2);
  assign poll_drop = (op_q == OP_POLL) && ext_q &&
                     (edge_gap > {16'd0, cfg_i.ext_timeout_ms});
  assign raw_req   = (tap_third && (half != 32'd0)) ||
                     ((op_q == OP_EDGE) && (edge_gap != 32'd0));

  assign sts_o.raw_req  = raw_req;
  assign sts_o.div_done = div_done;

  assign dividend = (cmd_i.div_sel == SEL_PERIOD) ? PERIOD_NUM : MS_PER_MIN;
  assign divisor  = (cmd_i.div_sel == SEL_PERIOD) ? {23'd0, tempo_q} : opnd_q;

  // 60000 / x never exceeds 16 bits
  assign raw      = quot[15:0];
  assign raw_diff = (raw > {7'd0, tempo_q}) ? (raw - {7'd0, tempo_q})
                                            : ({7'd0, tempo_q} - raw);
  assign retune   = (op_q == OP_TAP) || (raw_diff > {8'd0, cfg_i.change_threshold});

  ttt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tempo_q     <= TEMPO_RST;
      cnt_q       <= 3'd0;
      last_tap_q  <= 32'd0;
      last_edge_q <= 32'd0;
      ext_q       <= 1'b0;
      upd_q       <= 1'b0;
      restart_q   <= 1'b0;
    end else if (cmd_i.load) begin
      upd_q     <= 1'b0;
      restart_q <= 1'b0;
    end else if (cmd_i.eval) begin
      case (op_q)
        OP_TAP: begin
          if (!ext_q) begin
            if (cnt_eff < 3'd3) begin
              last_tap_q <= now_q;
              cnt_q      <= (cnt_eff == 3'd2) ? 3'd4 : (cnt_eff + 3'd1);
            end else begin
              cnt_q <= cnt_eff;
            end
            if (tap_third && (half == 32'd0)) begin
              tempo_q <= clamp_bpm({7'd0, cfg_i.max_bpm}, cfg_i.min_bpm, cfg_i.max_bpm);
              upd_q   <= 1'b1;
            end
          end
        end
        OP_EDGE: begin
          last_edge_q <= now_q;
          ext_q       <= 1'b1;
          restart_q   <= 1'b1;
        end
        OP_POLL: begin
          if (poll_drop) begin
            ext_q   <= 1'b0;
            tempo_q <= clamp_bpm({7'd0, cfg_i.fallback_bpm}, cfg_i.min_bpm,
                                 cfg_i.max_bpm);
            upd_q   <= 1'b1;
          end
        end
        default: ;
      endcase
    end else if (cmd_i.apply_raw && retune) begin
      tempo_q <= clamp_bpm(raw, cfg_i.min_bpm, cfg_i.max_bpm);
      upd_q   <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_i;
      now_q <= now_i;
    end
    if (cmd_i.eval) begin
      opnd_q <= tap_third ? half : edge_gap;
      if (tap_go && (cnt_eff == 3'd0)) begin
        t0_q <= now_q;
      end
    end
    if (cmd_i.out_load) begin
      bpm_q         <= tempo_q;
      period_q      <= (tempo_q == 9'd0) ? PERIOD_NUM : quot;
      ext_out_q     <= ext_q;
      upd_out_q     <= upd_q;
      restart_out_q <= restart_q;
    end
  end

  assign bpm_o     = bpm_q;
  assign period_o  = period_q;
  assign ext_o     = ext_out_q;
  assign upd_o     = upd_out_q;
  assign restart_o = restart_out_q;

endmodule

`default_nettype wire

// ----- rtl/core/ttt_ctrl.sv -----
// ----------------------------------------------------------------------------
// ttt_ctrl
// Sequencer: accepts an event, steps the datapath through evaluation and one or
// two divider passes, and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ttt_ctrl
  import ttt_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire sts_t sts_i,
  input  wire logic s_tvalid_i,
  input  wire logic m_tready_i,
  output logic      s_tready_o,
  output logic      m_tvalid_o,
  output cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_RAW_GO,
    ST_RAW_WAIT,
    ST_PER_GO,
    ST_PER_WAIT,
    ST_EMIT
  } state_e;

  state_e state_q;
  logic   m_tvalid_q;
  logic   out_free;

  assign out_free   = !m_tvalid_q || m_tready_i;
  assign s_tready_o = (state_q == ST_IDLE);
  assign m_tvalid_o = m_tvalid_q;

  always_comb begin
    cmd_o.load      = (state_q == ST_IDLE) && s_tvalid_i;
    cmd_o.eval      = (state_q == ST_EVAL);
    cmd_o.div_start = (state_q == ST_RAW_GO) || (state_q == ST_PER_GO);
    cmd_o.div_sel   = (state_q == ST_PER_GO) ? SEL_PERIOD : SEL_RAW;
    cmd_o.apply_raw = (state_q == ST_RAW_WAIT) && sts_i.div_done;
    cmd_o.out_load  = (state_q == ST_EMIT) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      m_tvalid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        m_tvalid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_tvalid_i) begin
            state_q <= ST_EVAL;
          end
        end
        ST_EVAL:     state_q <= sts_i.raw_req ? ST_RAW_GO : ST_PER_GO;
        ST_RAW_GO:   state_q <= ST_RAW_WAIT;
        ST_RAW_WAIT: begin
          if (sts_i.div_done) begin
            state_q <= ST_PER_GO;
          end
        end
        ST_PER_GO:   state_q <= ST_PER_WAIT;
        ST_PER_WAIT: begin
          if (sts_i.div_done) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default:     state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/tap_and_external_tempo_tracker_top.sv -----
// ----------------------------------------------------------------------------
// tap_and_external_tempo_tracker_top
// Tempo tracker driven by taps, external clock edges and time polls.
//
//   channel   dir  handshake               payload
//   s_axis    in   tvalid/tready           tuser: op, tdata: now_ms
//   m_axis    out  tvalid/tready           tdata: bpm, period_us, flags
//   apb       in   psel/penable/pwrite     6 config registers at 4*i
//
// Events are handled one at a time: evaluate, an optional raw-tempo pass and a
// period pass of the shared radix-2 divider, then the output register.
// Reset is asynchronous, active low; all tempo state returns to its defaults.
// The next event is taken while a result waits in the output register; a
// stalled m_axis holds the sequencer before it overwrites that register.
// ----------------------------------------------------------------------------
`default_nettype none

module tap_and_external_tempo_tracker_top
  import ttt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] now_ms
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] op
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [31:0] m_axis_tdata,   // [8:0] bpm, [26:9] period_us,
                                           // [27] external_active,
                                           // [28] tempo_updated,
                                           // [29] restart_ticks, [31:30] zero
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  cfg_t        cfg;
  cmd_t        cmd;
  sts_t        sts;
  logic [8:0]  bpm;
  logic [17:0] period;
  logic        ext;
  logic        upd;
  logic        restart;

  ttt_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr_idx_i (paddr[4:2]),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .cfg_o       (cfg)
  );

  ttt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sts_i      (sts),
    .s_tvalid_i (s_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .cmd_o      (cmd)
  );

  ttt_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .op_i      (s_axis_tuser),
    .now_i     (s_axis_tdata),
    .cfg_i     (cfg),
    .sts_o     (sts),
    .bpm_o     (bpm),
    .period_o  (period),
    .ext_o     (ext),
    .upd_o     (upd),
    .restart_o (restart)
  );

  assign m_axis_tdata = {2'b00, restart, upd, ext, period, bpm};

endmodule

`default_nettype wire

// ----- rtl/core/ttt_chk.sv -----
// ----------------------------------------------------------------------------
// ttt_chk
// Port-level checks on the tempo tracker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ttt_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata
);

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed under stall");

  // one event in flight
  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second event taken while busy");

  a_restart_ext: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[29] || m_axis_tdata[27])
    else $error("tick restart without external mode");

  a_zero_tempo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[8:0] == 9'd0) |-> m_axis_tdata[26:9] == 18'd156250)
    else $error("zero tempo period wrong");

endmodule

bind tap_and_external_tempo_tracker_top ttt_chk u_ttt_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- sim/tap_and_external_tempo_tracker_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tap_and_external_tempo_tracker_top_test
// Self-checking bench for the tempo tracker. Events go in as stream beats
// with random gaps. A behavioural tempo tracker in the bench predicts every
// result beat, and each one is checked field by field as it comes out under
// random back-pressure. Registers are set over APB between phases and read
// back: reset values, clamp extremes, inverted clamps, zero tempo and random
// settings.
// ----------------------------------------------------------------------------

module tap_and_external_tempo_tracker_top_test;
  import ttt_pkg::*;

  localparam op_t         OP_IDLE      = 2'd3;
  localparam int unsigned STALL_LIMIT  = 6000;
  localparam int unsigned CHOKE_CYCLES = 600;
  localparam int unsigned SETTLE       = 60;

  typedef struct {
    op_t         op;
    logic [31:0] now;
    int unsigned gap;
  } tempo_event_t;

  typedef struct {
    logic [8:0]  bpm;
    logic [17:0] period;
    logic        ext;
    logic        upd;
    logic        restart;
  } tempo_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;   // [31:0] now_ms
  logic [1:0]  s_axis_tuser  = '0;   // [1:0] op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;         // [8:0] bpm, [26:9] period_us, [27] external_active,
                                     // [28] tempo_updated, [29] restart_ticks
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [4:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  tap_and_external_tempo_tracker_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // register copies
  logic [15:0] tap_to_c;
  logic [15:0] ext_to_c;
  logic [8:0]  min_bpm_c;
  logic [8:0]  max_bpm_c;
  logic [7:0]  thresh_c;
  logic [8:0]  fallback_c;

  // tracker state
  logic [8:0]  cur_tempo;
  logic [31:0] tap_stamp [3];
  logic [2:0]  taps_held;
  logic [31:0] last_tap;
  logic [31:0] last_edge;
  logic        ext_on;

  tempo_event_t  pending_events [$];
  tempo_result_t tempo_expected [$];
  tempo_event_t  drv_ev;
  logic [31:0]   clock_ms;

  int unsigned src_wait;
  int unsigned sink_hold;
  int unsigned sink_run;
  bit          sink_quiet;
  int unsigned choke_left;
  int unsigned choke_reqs;
  int unsigned choke_seen;
  int unsigned stall_cycles = 0;
  int unsigned errors;
  int unsigned n_taps, n_edges, n_polls, n_idle, n_results, n_updates, n_settings;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- tracker
  function automatic logic [8:0] bound_tempo(input logic [31:0] raw);
    if (raw < {23'd0, min_bpm_c}) begin
      return min_bpm_c;
    end else if (raw > {23'd0, max_bpm_c}) begin
      return max_bpm_c;
    end
    return raw[8:0];
  endfunction

  task automatic reset_tracker();
    tap_to_c   = TAP_TO_RST;
    ext_to_c   = EXT_TO_RST;
    min_bpm_c  = MIN_BPM_RST;
    max_bpm_c  = MAX_BPM_RST;
    thresh_c   = THRESH_RST;
    fallback_c = FALLBACK_RST;
    cur_tempo  = TEMPO_RST;
    foreach (tap_stamp[i]) tap_stamp[i] = '0;
    taps_held  = '0;
    last_tap   = '0;
    last_edge  = '0;
    ext_on     = 1'b0;
  endtask

  task automatic track_event(input op_t op, input logic [31:0] now);
    tempo_result_t r;
    logic [31:0]   span;
    logic [31:0]   half;
    logic [31:0]   raw;
    logic [31:0]   gap;
    logic [31:0]   diff;
    r.upd     = 1'b0;
    r.restart = 1'b0;
    case (op)
      OP_TAP: begin
        n_taps++;
        if (!ext_on) begin
          gap = now - last_tap;
          if (gap > {16'd0, tap_to_c}) taps_held = '0;
          if (taps_held < 3) begin
            tap_stamp[taps_held] = now;
            taps_held++;
            last_tap = now;
          end
          if (taps_held == 3) begin
            span      = tap_stamp[2] - tap_stamp[0];
            half      = span >> 1;
            raw       = (half == 0) ? {23'd0, max_bpm_c} : {14'd0, MS_PER_MIN} / half;
            taps_held = 3'd4;
            cur_tempo = bound_tempo(raw);
            r.upd     = 1'b1;
          end
        end
      end
      OP_EDGE: begin
        n_edges++;
        gap       = now - last_edge;
        last_edge = now;
        if (gap != 0) begin
          raw  = {14'd0, MS_PER_MIN} / gap;
          diff = (raw > {23'd0, cur_tempo}) ? raw - {23'd0, cur_tempo}
                                            : {23'd0, cur_tempo} - raw;
          if (diff > {24'd0, thresh_c}) begin
            cur_tempo = bound_tempo(raw);
            r.upd     = 1'b1;
          end
        end
        ext_on    = 1'b1;
        r.restart = 1'b1;
      end
      OP_POLL: begin
        n_polls++;
        gap = now - last_edge;
        if (ext_on && gap > {16'd0, ext_to_c}) begin
          ext_on    = 1'b0;
          cur_tempo = bound_tempo({23'd0, fallback_c});
          r.upd     = 1'b1;
        end
      end
      default: n_idle++;
    endcase
    r.bpm    = cur_tempo;
    r.period = (cur_tempo == 0) ? PERIOD_NUM : PERIOD_NUM / {9'd0, cur_tempo};
    r.ext    = ext_on;
    tempo_expected.push_back(r);
    if (r.upd) n_updates++;
  endtask

  // ----------------------------------------------------------------- driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      src_wait = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) track_event(s_axis_tuser, s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_events.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (src_wait < pending_events[0].gap) begin
          src_wait++;
          s_axis_tvalid <= 1'b0;
        end else begin
          drv_ev = pending_events.pop_front();
          s_axis_tdata  <= drv_ev.now;
          s_axis_tuser  <= drv_ev.op;
          s_axis_tvalid <= 1'b1;
          src_wait = 0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
    $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    errors++;
  endtask

  task automatic check_result(input logic [31:0] d);
    tempo_result_t w;
    n_results++;
    if (tempo_expected.size() == 0) begin
      $display("%0t: result beat %h with nothing expected", $time, d);
      errors++;
    end else begin
      w = tempo_expected.pop_front();
      if (d[8:0]  !== w.bpm)     report("bpm", w.bpm, d[8:0]);
      if (d[26:9] !== w.period)  report("period_us", w.period, d[26:9]);
      if (d[27]   !== w.ext)     report("external_active", w.ext, d[27]);
      if (d[28]   !== w.upd)     report("tempo_updated", w.upd, d[28]);
      if (d[29]   !== w.restart) report("restart_ticks", w.restart, d[29]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_hold  = 0;
      sink_run   = 0;
      sink_quiet = 1'b0;
      choke_left = 0;
      choke_seen = 0;
    end else begin
      if (choke_seen != choke_reqs) begin
        choke_seen = choke_reqs;
        choke_left = CHOKE_CYCLES;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        check_result(m_axis_tdata);
        if (sink_run == 0) begin
          sink_quiet = ($urandom_range(0, 2) == 0);
          sink_run   = $urandom_range(10, 60);
        end
        sink_run--;
        sink_hold = sink_quiet ? 0 : $urandom_range(0, 13);
      end else if (sink_hold != 0) begin
        sink_hold--;
      end
      if (choke_left != 0) begin
        choke_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= (sink_hold == 0);
      end
    end
  end

  // --------------------------------------------------------------- watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
    $display("tap_and_external_tempo_tracker_top: mismatch");
    $finish;
  end

  // -------------------------------------------------------------------- APB
  task automatic apb_access(input reg_idx_t idx, input bit wr, input logic [31:0] val,
                            output logic [31:0] rd);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic read_check(input reg_idx_t idx, input logic [31:0] want);
    logic [31:0] rd;
    apb_access(idx, 1'b0, '0, rd);
    if (rd !== want) begin
      $display("%0t: register %0d read expected %h actual %h", $time, idx, want, rd);
      errors++;
    end
  endtask

  task automatic check_regs();
    read_check(REG_TAP_TO,   {16'd0, tap_to_c});
    read_check(REG_EXT_TO,   {16'd0, ext_to_c});
    read_check(REG_MIN_BPM,  {23'd0, min_bpm_c});
    read_check(REG_MAX_BPM,  {23'd0, max_bpm_c});
    read_check(REG_THRESH,   {24'd0, thresh_c});
    read_check(REG_FALLBACK, {23'd0, fallback_c});
  endtask

  task automatic set_config(input int unsigned tap_to, input int unsigned ext_to,
                            input int unsigned lo, input int unsigned hi,
                            input int unsigned thr, input int unsigned fb);
    logic [31:0] rd;
    apb_access(REG_TAP_TO,   1'b1, tap_to, rd);
    apb_access(REG_EXT_TO,   1'b1, ext_to, rd);
    apb_access(REG_MIN_BPM,  1'b1, lo, rd);
    apb_access(REG_MAX_BPM,  1'b1, hi, rd);
    apb_access(REG_THRESH,   1'b1, thr, rd);
    apb_access(REG_FALLBACK, 1'b1, fb, rd);
    tap_to_c   = tap_to[15:0];
    ext_to_c   = ext_to[15:0];
    min_bpm_c  = lo[8:0];
    max_bpm_c  = hi[8:0];
    thresh_c   = thr[7:0];
    fallback_c = fb[8:0];
    n_settings++;
    check_regs();
  endtask

  // --------------------------------------------------------------- stimulus
  task automatic push_event(input op_t op, input logic [31:0] now, input bit quiet);
    tempo_event_t ev;
    ev.op  = op;
    ev.now = now;
    ev.gap = quiet ? 0 : $urandom_range(0, 13);
    pending_events.push_back(ev);
  endtask

  task automatic drain();
    while (pending_events.size() != 0 || tempo_expected.size() != 0 || s_axis_tvalid) begin
      @(posedge clk_i);
    end
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic logic [31:0] tap_gap();
    case ($urandom_range(0, 9))
      0:       return {16'd0, tap_to_c};
      1:       return {16'd0, tap_to_c} + 1;
      2:       return 0;
      default: return $urandom_range(0, tap_to_c);
    endcase
  endfunction

  function automatic logic [31:0] poll_gap();
    case ($urandom_range(0, 5))
      0:       return {16'd0, ext_to_c};
      1:       return {16'd0, ext_to_c} + 1;
      2:       return $urandom_range(0, ext_to_c);
      default: return {16'd0, ext_to_c} + $urandom_range(1, 4000);
    endcase
  endfunction

  task automatic add_events(input int unsigned n);
    int unsigned made;
    int unsigned len;
    int unsigned base;
    bit          quiet;
    made = 0;
    while (made < n) begin
      quiet = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          if ($urandom_range(0, 1) == 0) begin
            clock_ms += {16'd0, ext_to_c} + 1 + $urandom_range(0, 50);
            push_event(OP_POLL, clock_ms, quiet);
            made++;
          end
          len = $urandom_range(2, 5);
          repeat (len) begin
            clock_ms += tap_gap();
            push_event(OP_TAP, clock_ms, quiet);
          end
          made += len;
        end
        4, 5, 6: begin
          base = $urandom_range(100, 6000);
          len  = $urandom_range(2, 8);
          repeat (len) begin
            if ($urandom_range(0, 19) != 0) clock_ms += base + $urandom_range(0, 40) - 20;
            push_event(OP_EDGE, clock_ms, quiet);
          end
          made += len;
        end
        7, 8: begin
          len = $urandom_range(1, 3);
          repeat (len) begin
            clock_ms += poll_gap();
            push_event(OP_POLL, clock_ms, quiet);
          end
          made += len;
        end
        default: begin
          if ($urandom_range(0, 1) == 0) clock_ms = $urandom;
          push_event(op_t'($urandom_range(0, 3)), clock_ms, quiet);
          made++;
        end
      endcase
    end
  endtask

  task automatic directed_events();
    push_event(OP_POLL, 32'd0,     1'b0);
    push_event(OP_TAP,  32'd100,   1'b0);
    push_event(OP_TAP,  32'd600,   1'b1);
    push_event(OP_TAP,  32'd1100,  1'b0);   // 120 bpm
    push_event(OP_TAP,  32'd1200,  1'b0);   // capture full
    push_event(OP_TAP,  32'd5000,  1'b0);   // timeout restarts
    push_event(OP_TAP,  32'd5000,  1'b1);
    push_event(OP_TAP,  32'd5001,  1'b0);   // half span rounds to zero
    push_event(OP_TAP,  32'd9000,  1'b0);
    push_event(OP_TAP,  32'd9001,  1'b0);
    push_event(OP_TAP,  32'd9003,  1'b0);   // 60000, clamped high
    push_event(OP_EDGE, 32'd30000, 1'b0);   // clamped low
    push_event(OP_EDGE, 32'd30000, 1'b1);   // zero interval
    push_event(OP_EDGE, 32'd30500, 1'b0);
    push_event(OP_EDGE, 32'd31001, 1'b0);   // within threshold
    push_event(OP_TAP,  32'd31100, 1'b0);   // ignored, external active
    push_event(OP_POLL, 32'd33001, 1'b0);   // exactly at timeout
    push_event(OP_POLL, 32'd33002, 1'b0);   // falls back
    push_event(OP_TAP,  32'hFFFF_FF00, 1'b0);
    push_event(OP_TAP,  32'h0000_0100, 1'b0);
    push_event(OP_TAP,  32'h0000_0300, 1'b0);   // span across wrap
    push_event(OP_EDGE, 32'hFFFF_FFFF, 1'b0);
    push_event(OP_EDGE, 32'h0000_001F, 1'b0);   // interval across wrap
    push_event(OP_IDLE, 32'hFFFF_FFFF, 1'b0);
    push_event(OP_POLL, 32'h0000_07F0, 1'b0);
  endtask

  function automatic int unsigned pick_timeout();
    return ($urandom_range(0, 1) == 0) ? $urandom_range(200, 4000) : $urandom_range(0, 65535);
  endfunction

  initial begin
    errors     = 0;
    choke_reqs = 0;
    n_taps = 0; n_edges = 0; n_polls = 0; n_idle = 0;
    n_results = 0; n_updates = 0; n_settings = 1;
    reset_tracker();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_regs();

    directed_events();
    clock_ms = 32'd40000;
    add_events(200);
    drain();

    // wide limits, with a long receiver stall at the start
    set_config(65535, 65535, 1, 511, 0, 511);
    choke_reqs++;
    clock_ms = $urandom;
    add_events(200);
    drain();

    set_config(1, 1, 1, 511, 255, 1);
    add_events(150);
    drain();

    // inverted clamp range: values below the lower bound take it, all others take the upper bound
    set_config(3000, 500, 200, 100, 3, 150);
    add_events(150);
    drain();

    // zero tempo
    set_config(2000, 2000, 0, 0, 0, 0);
    clock_ms += 32'd70000;
    push_event(OP_POLL, clock_ms, 1'b0);
    push_event(OP_TAP,  clock_ms, 1'b0);
    push_event(OP_TAP,  clock_ms, 1'b0);
    push_event(OP_TAP,  clock_ms, 1'b0);
    push_event(OP_EDGE, clock_ms + 500, 1'b0);
    push_event(OP_EDGE, clock_ms + 1000, 1'b0);
    clock_ms += 1000;
    add_events(60);
    drain();

    repeat (5) begin
      set_config(pick_timeout(), pick_timeout(),
                 ($urandom_range(0, 1) == 0) ? $urandom_range(1, 60) : $urandom_range(0, 511),
                 ($urandom_range(0, 1) == 0) ? $urandom_range(150, 511) : $urandom_range(0, 511),
                 $urandom_range(0, 255), $urandom_range(0, 511));
      clock_ms = $urandom;
      add_events(180);
      drain();
    end

    $display("Ran %0d events (%0d taps, %0d edges, %0d polls, %0d no-ops), %0d results",
             n_taps + n_edges + n_polls + n_idle, n_taps, n_edges, n_polls, n_idle, n_results);
    $display("%0d tempo changes over %0d register settings", n_updates, n_settings);
    if (tempo_expected.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, tempo_expected.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tap_and_external_tempo_tracker_top: match");
    end else begin
      $display("tap_and_external_tempo_tracker_top: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/ttt_pkg.sv
rtl/core/ttt_regs.sv
rtl/core/ttt_div.sv
rtl/core/ttt_dp.sv
rtl/core/ttt_ctrl.sv
rtl/core/tap_and_external_tempo_tracker_top.sv
rtl/core/ttt_chk.sv
sim/tap_and_external_tempo_tracker_top_test.sv
